### hdl/indexed_min_heap_assert.svh
// ----------------------------------------------------------------------------
// indexed_min_heap_assert.svh
// Assertion macros for the indexed min-heap. They use the clock and reset
// names of the module that expands them.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_ASSERT_SVH
`define INDEXED_MIN_HEAP_ASSERT_SVH

// same-cycle implication
`define IMH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IMH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Types and constants shared by the indexed min-heap modules.
// ----------------------------------------------------------------------------
package imh_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int SLOT_W       = $clog2(MAX_VERTICES);
   localparam int SIZE_W       = SLOT_W + 1;
   localparam int CHILD_W      = SLOT_W + 2;
   localparam int VTX_W        = 8;
   localparam int KEY_W        = 24;
   localparam int VCOUNT_W     = 9;
   localparam int CSR_W        = 24;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [VCOUNT_W-1:0] RESET_VERTEX_COUNT = VCOUNT_W'(256);
   localparam logic [KEY_W-1:0]    RESET_INFINITY_KEY = KEY_W'(99999);

   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFINITY_KEY = 1'b1;

   typedef enum logic [1:0] {
      CMD_INIT     = 2'd0,
      CMD_DECREASE = 2'd1,
      CMD_EXTRACT  = 2'd2,
      CMD_CONTAINS = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic [VTX_W-1:0]   vertex;
      logic [KEY_W-1:0]   new_key;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0]   out_vertex;
      logic [KEY_W-1:0]   out_key;
      logic               was_empty;
      logic               is_member;
      logic [SIZE_W-1:0]  entries_left;
   } rsp_type;

   // one heap slot: vertex number and its key
   typedef struct packed {
      logic [VTX_W-1:0]   vertex;
      logic [KEY_W-1:0]   key;
   } slot_entry_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  addr;
      slot_entry_type     entry;
   } slot_wr_type;

   typedef struct packed {
      logic               en;
      logic [VTX_W-1:0]   addr;
      logic [SLOT_W-1:0]  slot;
   } pos_wr_type;

endpackage

### hdl/imh_store.sv
// ----------------------------------------------------------------------------
// imh_store
// Heap slot memory and vertex position memory, each one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module imh_store
   import imh_pkg::*;
(
   input  logic                 clock,
   input  logic [SLOT_W-1:0]    slot_rd_addr,
   input  slot_wr_type          slot_wr,
   output slot_entry_type       slot_rd_data,
   input  logic [VTX_W-1:0]     pos_rd_addr,
   input  pos_wr_type           pos_wr,
   output logic [SLOT_W-1:0]    pos_rd_data
);

   slot_entry_type    slot_mem [MAX_VERTICES];
   logic [SLOT_W-1:0] pos_mem  [MAX_VERTICES];

   always_ff @(posedge clock) begin
      if (slot_wr.en) begin
         slot_mem[slot_wr.addr] <= slot_wr.entry;
      end
      slot_rd_data <= slot_mem[slot_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pos_wr.en) begin
         pos_mem[pos_wr.addr] <= pos_wr.slot;
      end
      pos_rd_data <= pos_mem[pos_rd_addr];
   end

endmodule

### hdl/indexed_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of vertices keyed by distance, with a map from
// vertex to heap slot; commands init, decrease_key, extract_min, contains.
// ----------------------------------------------------------------------------
// A command transfers at a rising edge with start high and busy low; busy
// then stays high until the command is done, but init with n = 0 and
// extract_min on an empty heap finish without raising busy. The result comes
// on rsp_payload for exactly one cycle with rsp_strobe high and cannot be
// held off, so take it in that cycle. start may be raised again in that same
// cycle. init writes one slot per cycle, n = vertex_count clamped to 256
// slots. decrease_key leaves a non-member untouched and otherwise sifts the
// vertex up; extract_min sifts the last entry down from the root. The slot
// memory has a single read port: each sift step reads the parent, or the two
// children one after the other, and writes the parent or the smaller child
// into the hole; the moving entry is written once, where it ends.
// Configuration writes go through the csr port only while the block is idle;
// the user is bound to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "indexed_min_heap_assert.svh"

module indexed_min_heap
   import imh_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_payload,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_payload,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_FILL,
      ST_MB_POS,
      ST_MB_CHK,
      ST_SU_RD,
      ST_SU_CMP,
      ST_EX_ROOT,
      ST_EX_LAST,
      ST_SD_RL,
      ST_SD_RR,
      ST_SD_CMP
   } state_type;

   // control registers
   state_type            state_ff, state_in;
   logic                 strobe_ff, strobe_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [VCOUNT_W-1:0]  vcount_ff, vcount_in;
   logic [KEY_W-1:0]     inf_ff, inf_in;

   // working registers
   rsp_type              rsp_ff, rsp_in;
   cmd_type              cmd_ff, cmd_in;
   logic [VTX_W-1:0]     vtx_ff, vtx_in;
   slot_entry_type       cur_ff, cur_in;      // entry that moves through the hole
   slot_entry_type       root_ff, root_in;    // extracted root
   slot_entry_type       lchild_ff, lchild_in;
   logic [SLOT_W-1:0]    hole_ff, hole_in;    // hole slot, also init sweep index
   logic [SIZE_W-1:0]    count_ff, count_in;  // init fill length

   // memory ports
   logic [SLOT_W-1:0]    slot_rd_addr;
   slot_wr_type          slot_wr;
   slot_entry_type       slot_rd_data;
   logic [VTX_W-1:0]     pos_rd_addr;
   pos_wr_type           pos_wr;
   logic [SLOT_W-1:0]    pos_rd_data;

   // heap index arithmetic
   logic [CHILD_W-1:0]   l_idx, r_idx;
   logic                 l_in_heap, r_in_heap;
   logic [SLOT_W-1:0]    hole_m1, parent;
   logic [SLOT_W-1:0]    last_slot;
   logic [SIZE_W-1:0]    init_n;

   // result control
   logic                 finish, empty_hit, member_hit, mem_ok;
   logic                 take_l, take_r;
   logic [KEY_W-1:0]     best_key;

   imh_store u_store (
      .clock        (clock),
      .slot_rd_addr (slot_rd_addr),
      .slot_wr      (slot_wr),
      .slot_rd_data (slot_rd_data),
      .pos_rd_addr  (pos_rd_addr),
      .pos_wr       (pos_wr),
      .pos_rd_data  (pos_rd_data)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

   assign l_idx     = CHILD_W'({hole_ff, 1'b1});
   assign r_idx     = CHILD_W'({hole_ff, 1'b0}) + CHILD_W'(2);
   assign l_in_heap = (l_idx < CHILD_W'(size_ff));
   assign r_in_heap = (r_idx < CHILD_W'(size_ff));
   assign hole_m1   = hole_ff - SLOT_W'(1);
   assign parent    = {1'b0, hole_m1[SLOT_W-1:1]};
   assign last_slot = SLOT_W'(size_ff - SIZE_W'(1));
   // init count clamped to the heap capacity
   assign init_n    = (vcount_ff > VCOUNT_W'(MAX_VERTICES)) ? SIZE_W'(MAX_VERTICES)
                                                            : SIZE_W'(vcount_ff);

   // membership: mapped slot inside the heap and pointing back at the vertex
   assign mem_ok    = (SIZE_W'(hole_ff) < size_ff) && (slot_rd_data.vertex == vtx_ff);

   // sift-down child choice, left child wins ties
   assign take_l    = (lchild_ff.key < cur_ff.key);
   assign best_key  = take_l ? lchild_ff.key : cur_ff.key;
   assign take_r    = r_in_heap && (slot_rd_data.key < best_key);

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      vcount_in    = vcount_ff;
      inf_in       = inf_ff;
      cmd_in       = cmd_ff;
      vtx_in       = vtx_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      lchild_in    = lchild_ff;
      hole_in      = hole_ff;
      count_in     = count_ff;
      slot_rd_addr = '0;
      pos_rd_addr  = req_payload.vertex;
      slot_wr      = '0;
      pos_wr       = '0;
      finish       = 1'b0;
      empty_hit    = 1'b0;
      member_hit   = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_in = csr_wdata[VCOUNT_W-1:0];
            CSR_INFINITY_KEY: inf_in    = csr_wdata[KEY_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // slot 0 is read ahead for extract_min
            if (start) begin
               cmd_in = req_payload.command;
               vtx_in = req_payload.vertex;
               cur_in = '{vertex: req_payload.vertex, key: req_payload.new_key};
               case (req_payload.command)
                  CMD_INIT: begin
                     if (init_n == '0) begin
                        size_in = '0;
                        finish  = 1'b1;
                     end else begin
                        count_in = init_n;
                        hole_in  = '0;
                        state_in = ST_INIT_FILL;
                     end
                  end
                  CMD_EXTRACT: begin
                     if (size_ff == '0) begin
                        empty_hit = 1'b1;
                        finish    = 1'b1;
                     end else begin
                        state_in = ST_EX_ROOT;
                     end
                  end
                  default: state_in = ST_MB_POS;
               endcase
            end
         end

         ST_INIT_FILL: begin
            slot_wr = '{en: 1'b1, addr: hole_ff,
                        entry: '{vertex: VTX_W'(hole_ff), key: inf_ff}};
            pos_wr  = '{en: 1'b1, addr: VTX_W'(hole_ff), slot: hole_ff};
            if (SIZE_W'(hole_ff) + SIZE_W'(1) == count_ff) begin
               size_in = count_ff;
               finish  = 1'b1;
            end else begin
               hole_in = hole_ff + SLOT_W'(1);
            end
         end

         ST_MB_POS: begin
            slot_rd_addr = pos_rd_data;
            hole_in      = pos_rd_data;
            state_in     = ST_MB_CHK;
         end

         ST_MB_CHK: begin
            if (cmd_ff == CMD_CONTAINS) begin
               member_hit = mem_ok;
               finish     = 1'b1;
            end else if (mem_ok) begin
               state_in = ST_SU_RD;
            end else begin
               finish = 1'b1;
            end
         end

         ST_SU_RD: begin
            if (hole_ff == '0) begin
               slot_wr = '{en: 1'b1, addr: hole_ff, entry: cur_ff};
               pos_wr  = '{en: 1'b1, addr: cur_ff.vertex, slot: hole_ff};
               finish  = 1'b1;
            end else begin
               slot_rd_addr = parent;
               state_in     = ST_SU_CMP;
            end
         end

         ST_SU_CMP: begin
            // strict less-than moves the parent down into the hole
            if (cur_ff.key < slot_rd_data.key) begin
               slot_wr  = '{en: 1'b1, addr: hole_ff, entry: slot_rd_data};
               pos_wr   = '{en: 1'b1, addr: slot_rd_data.vertex, slot: hole_ff};
               hole_in  = parent;
               state_in = ST_SU_RD;
            end else begin
               slot_wr = '{en: 1'b1, addr: hole_ff, entry: cur_ff};
               pos_wr  = '{en: 1'b1, addr: cur_ff.vertex, slot: hole_ff};
               finish  = 1'b1;
            end
         end

         ST_EX_ROOT: begin
            root_in      = slot_rd_data;
            slot_rd_addr = last_slot;
            state_in     = ST_EX_LAST;
         end

         ST_EX_LAST: begin
            // removed root parks just past the new heap end
            cur_in   = slot_rd_data;
            slot_wr  = '{en: 1'b1, addr: last_slot, entry: root_ff};
            pos_wr   = '{en: 1'b1, addr: root_ff.vertex, slot: last_slot};
            size_in  = size_ff - SIZE_W'(1);
            hole_in  = '0;
            state_in = ST_SD_RL;
         end

         ST_SD_RL: begin
            if (!l_in_heap) begin
               slot_wr = '{en: 1'b1, addr: hole_ff, entry: cur_ff};
               pos_wr  = '{en: 1'b1, addr: cur_ff.vertex, slot: hole_ff};
               finish  = 1'b1;
            end else begin
               slot_rd_addr = l_idx[SLOT_W-1:0];
               state_in     = ST_SD_RR;
            end
         end

         ST_SD_RR: begin
            lchild_in    = slot_rd_data;
            slot_rd_addr = r_idx[SLOT_W-1:0];
            state_in     = ST_SD_CMP;
         end

         ST_SD_CMP: begin
            if (take_r) begin
               slot_wr  = '{en: 1'b1, addr: hole_ff, entry: slot_rd_data};
               pos_wr   = '{en: 1'b1, addr: slot_rd_data.vertex, slot: hole_ff};
               hole_in  = r_idx[SLOT_W-1:0];
               state_in = ST_SD_RL;
            end else if (take_l) begin
               slot_wr  = '{en: 1'b1, addr: hole_ff, entry: lchild_ff};
               pos_wr   = '{en: 1'b1, addr: lchild_ff.vertex, slot: hole_ff};
               hole_in  = l_idx[SLOT_W-1:0];
               state_in = ST_SD_RL;
            end else begin
               slot_wr = '{en: 1'b1, addr: hole_ff, entry: cur_ff};
               pos_wr  = '{en: 1'b1, addr: cur_ff.vertex, slot: hole_ff};
               finish  = 1'b1;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // result assembly
      strobe_in = finish;
      rsp_in    = rsp_ff;
      if (finish) begin
         state_in            = ST_IDLE;
         rsp_in.out_vertex   = vtx_in;
         rsp_in.out_key      = '0;
         rsp_in.was_empty    = empty_hit;
         rsp_in.is_member    = member_hit;
         rsp_in.entries_left = size_in;
         if (cmd_in == CMD_EXTRACT) begin
            rsp_in.out_vertex = empty_hit ? '0 : root_ff.vertex;
            rsp_in.out_key    = empty_hit ? '0 : root_ff.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         size_ff   <= '0;
         vcount_ff <= RESET_VERTEX_COUNT;
         inf_ff    <= RESET_INFINITY_KEY;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         size_ff   <= size_in;
         vcount_ff <= vcount_in;
         inf_ff    <= inf_in;
      end
      rsp_ff    <= rsp_in;
      cmd_ff    <= cmd_in;
      vtx_ff    <= vtx_in;
      cur_ff    <= cur_in;
      root_ff   <= root_in;
      lchild_ff <= lchild_in;
      hole_ff   <= hole_in;
      count_ff  <= count_in;
   end

   // checks
   `IMH_ASSERT_SAME(a_strobe_idle, rsp_strobe, !busy, "result strobe while busy")
   `IMH_ASSERT_SAME(a_empty_fields, rsp_strobe && rsp_payload.was_empty, (rsp_payload.entries_left == '0) && (rsp_payload.out_key == '0), "empty result with data")
   `IMH_ASSERT_NEXT(a_empty_extract, start && !busy && (req_payload.command == CMD_EXTRACT) && (size_ff == '0), rsp_strobe && rsp_payload.was_empty, "empty extract not answered")
   `IMH_ASSERT_NEXT(a_no_spurious, !busy && !start, !rsp_strobe, "result without command")

endmodule
